// ===== rtl/core/utf8_stream_decoder_top_assert.svh =====
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define U8SD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define U8SD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/u8sd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [30:0] cp_type;
   typedef logic [2:0]  len_type;
   typedef logic [2:0]  status_type;

   // Longest sequence accepted, 6 bytes.
   localparam len_type MaxSeqBytes = 3'd6;

   localparam status_type StSymbol  = 3'd0;
   localparam status_type StEnd     = 3'd1;
   localparam status_type StBadCont = 3'd2;
   localparam status_type StBadLead = 3'd3;
   localparam status_type StAbove16 = 3'd4;

   localparam cp_type Max16Bit = 31'h0000_FFFF;

endpackage

// ===== rtl/core/u8sd_req_if.sv =====
// Input byte channel.
interface u8sd_req_if;
   logic               valid;
   logic               ready;
   u8sd_pkg::byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/u8sd_rsp_if.sv =====
// Decoded result channel.
interface u8sd_rsp_if;
   logic                 valid;
   logic                 ready;
   u8sd_pkg::cp_type     code_point;
   u8sd_pkg::len_type    seq_length;
   u8sd_pkg::status_type status;

   modport source (output valid, output code_point, output seq_length, output status,
                   input ready);
   modport sink   (input valid, input code_point, input seq_length, input status,
                   output ready);
endinterface

// ===== rtl/core/u8sd_csr_if.sv =====
// Configuration write channel (limit_to_16_bit register).
interface u8sd_csr_if;
   logic valid;
   logic ready;
   logic limit_to_16_bit;

   modport source (output valid, output limit_to_16_bit, input ready);
   modport sink   (input valid, input limit_to_16_bit, output ready);
endinterface

// ===== rtl/core/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder: bytes in, code points (1 to 6 byte sequences) out.
//
// req_if carries one raw byte per item. rsp_if gives one item per completed
// sequence or event: code_point, seq_length and status (0 symbol, 1 end of
// text, 2 bad continuation, 3 invalid lead, 4 above 16 bits). Lead and
// continuation bytes that do not finish a sequence give no item.
// csr_if writes limit_to_16_bit; it is always ready and is to be written
// only while no sequence is in progress.
//
// Latency: the result of a byte is on rsp_if the cycle after the byte is
// accepted. Throughput: one byte per cycle while the receiver takes each
// result, set by the single output register behind the decode logic.
// When the receiver stalls, the result holds and req_if.ready drops until
// the result is taken; a byte that gives no result is still gated the same.
// Reset (synchronous, active high) clears the sequence state, empties the
// output register and sets limit_to_16_bit to 1.
module utf8_stream_decoder_top (
   input  logic             clock,
   input  logic             reset,
   u8sd_req_if.sink         req_if,
   u8sd_rsp_if.source       rsp_if,
   u8sd_csr_if.sink         csr_if
);
   import u8sd_pkg::*;

   logic       limit_ff, limit_in;
   cp_type     acc_ff, acc_in;
   len_type    remain_ff, remain_in;
   len_type    total_ff, total_in;

   logic       rsp_valid_ff, rsp_valid_in;
   cp_type     cp_ff, cp_in;
   len_type    len_ff, len_in;
   status_type status_ff, status_in;

   logic       req_fire;
   logic       emit;
   byte_type   b;
   len_type    taken;
   len_type    remain_dec;
   cp_type     acc_shift;
   len_type    lead_len;
   cp_type     lead_payload;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign b            = req_if.in_byte;

   assign taken      = total_ff - remain_ff + 3'd1;
   assign remain_dec = remain_ff - 3'd1;
   assign acc_shift  = {acc_ff[24:0], b[5:0]};

   always_comb begin
      lead_len     = 3'd0;
      lead_payload = '0;
      if (b[7:5] == 3'b110) begin
         lead_len     = 3'd2;
         lead_payload = {26'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_len     = 3'd3;
         lead_payload = {27'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_len     = 3'd4;
         lead_payload = {28'd0, b[2:0]};
      end else if (b[7:2] == 6'b111110) begin
         lead_len     = 3'd5;
         lead_payload = {29'd0, b[1:0]};
      end else if (b[7:1] == 7'b1111110) begin
         lead_len     = 3'd6;
         lead_payload = {30'd0, b[0]};
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      remain_in = remain_ff;
      total_in  = total_ff;
      emit      = 1'b0;
      cp_in     = '0;
      len_in    = 3'd1;
      status_in = StSymbol;
      if (remain_ff != 3'd0) begin
         if (b[7:6] != 2'b10) begin
            emit      = 1'b1;
            len_in    = taken;
            status_in = StBadCont;
            acc_in    = '0;
            remain_in = 3'd0;
            total_in  = 3'd0;
         end else begin
            acc_in    = acc_shift;
            remain_in = remain_dec;
            if (remain_dec == 3'd0) begin
               emit     = 1'b1;
               len_in   = total_ff;
               acc_in   = '0;
               total_in = 3'd0;
               if (limit_ff && (acc_shift > Max16Bit)) begin
                  status_in = StAbove16;
               end else begin
                  cp_in = acc_shift;
               end
            end
         end
      end else if (b == 8'h00) begin
         emit      = 1'b1;
         status_in = StEnd;
      end else if (!b[7]) begin
         emit  = 1'b1;
         cp_in = {23'd0, b};
      end else if ((lead_len == 3'd0) || (lead_len > MaxSeqBytes)) begin
         emit      = 1'b1;
         status_in = StBadLead;
      end else begin
         acc_in    = lead_payload;
         total_in  = lead_len;
         remain_in = lead_len - 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign limit_in = (csr_if.valid && csr_if.ready) ? csr_if.limit_to_16_bit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 1'b1;
         acc_ff       <= '0;
         remain_ff    <= 3'd0;
         total_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            acc_ff    <= acc_in;
            remain_ff <= remain_in;
            total_ff  <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         cp_ff     <= cp_in;
         len_ff    <= len_in;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.code_point = cp_ff;
   assign rsp_if.seq_length = len_ff;
   assign rsp_if.status     = status_ff;

`include "utf8_stream_decoder_top_assert.svh"

   `U8SD_ASSERT(a_err_cp_zero, rsp_valid_ff && (status_ff != StSymbol) |-> cp_ff == '0, "code point not zero on event")
   `U8SD_ASSERT(a_remain_lt_total, (remain_ff != 3'd0) |-> (remain_ff < total_ff) && (total_ff <= MaxSeqBytes), "sequence counters inconsistent")
   `U8SD_ASSERT(a_stall_blocks_req, rsp_valid_ff && !rsp_if.ready |-> !req_if.ready, "input taken while result stalled")
   `U8SD_ASSERT(a_len_range, rsp_valid_ff |-> (len_ff != 3'd0) && (len_ff <= MaxSeqBytes), "seq_length out of range")
   `U8SD_ASSERT_ALWAYS(a_reset_state, reset |=> limit_ff && (remain_ff == 3'd0) && !rsp_valid_ff, "state not cleared by reset")

endmodule
